### design/tkmq_pkg.sv
// Shared types, constants and helpers of the topic-keyed multi-queue FIFO.
package tkmq_pkg;

  localparam int unsigned NUM_QUEUES   = 2;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned NUM_CFG_REGS = 2;

  localparam int unsigned QueueW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned SlotW   = $clog2(QUEUE_DEPTH);
  localparam int unsigned FillW   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned StoreD  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int unsigned StoreAw = (StoreD > 1) ? $clog2(StoreD) : 1;
  localparam int unsigned CfgIdxW = (NUM_CFG_REGS > 1) ? $clog2(NUM_CFG_REGS) : 1;
  localparam int unsigned CfgDataW = 9;

  localparam logic       OP_PUSH = 1'b0;
  localparam logic       OP_POP  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_TOPIC = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic        operation;
    logic [7:0]  topic;
    logic [31:0] payload;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] entry_number;
    logic [31:0] data_out;
  } res_t;

  typedef struct packed {
    logic [15:0] seq;
    logic [31:0] data;
  } entry_t;

  typedef struct packed {
    logic signed [16:0] last_read;
    logic [15:0]        next_seq;
    logic [FillW-1:0]   fill;
    logic [SlotW-1:0]   wslot;
    logic [SlotW-1:0]   rslot;
  } ctrl_t;

  typedef struct packed {
    logic              hit;
    logic [QueueW-1:0] queue;
  } lookup_t;

  localparam ctrl_t CTRL_RESET = '{
    last_read: -17'sd1,
    next_seq:  16'd0,
    fill:      '0,
    wslot:     '0,
    rslot:     '0
  };

  function automatic logic [SlotW-1:0] slot_advance(input logic [SlotW-1:0] slot);
    logic [SlotW-1:0] nxt;
    if (slot == SlotW'(QUEUE_DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = slot + SlotW'(1);
    end
    return nxt;
  endfunction

endpackage

### design/topic_keyed_multi_queue_fifo_unit.sv
// Top level of the topic-keyed multi-queue FIFO: sequencer around two RAMs.
//
// A command is taken when start_i is high and busy_o is low. A push, a topic
// miss, a full push or an empty pop goes through the S_CTRL state and raises
// done_o at the same edge that clears busy, so the next command can already be
// taken while done_o is high. A successful pop also passes through the S_POP
// state, since it reads the per-queue control record RAM and then the entry
// RAM, each with registered read data. Each result shows on result_o for
// exactly one cycle with done_o high and cannot be held off. Queue topics are
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write them only
// while no command is in flight, which the block itself does not enforce. A
// negative topic leaves the queue unused.
module topic_keyed_multi_queue_fifo_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tkmq_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tkmq_pkg::CfgDataW-1:0] cfg_wdata_i,
  input  logic                          start_i,
  input  tkmq_pkg::cmd_t                cmd_i,
  output logic                          busy_o,
  output logic                          done_o,
  output tkmq_pkg::res_t                result_o
);
  import tkmq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CTRL = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              done_q, done_d;
  res_t              res_q, res_d;
  logic              op_q;
  logic [31:0]       payload_q;
  logic              hit_q;
  logic [QueueW-1:0] queue_q;
  ctrl_t             ctrl_hold_q;
  logic [NUM_QUEUES-1:0] ctrl_vld_q;

  lookup_t           match;
  ctrl_t             ctrl_rdata, ctrl_cur, ctrl_wdata;
  logic              ctrl_we;
  entry_t            ent_rdata, ent_wdata;
  logic              ent_we;
  logic [StoreAw-1:0] ent_base, ent_waddr, ent_raddr;
  logic              accept;

  assign accept = start_i && !busy_o;

  tkmq_lookup u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .topic_i     (cmd_i.topic),
    .match_o     (match)
  );

  tkmq_ram #(
    .Width ($bits(ctrl_t)),
    .Depth (NUM_QUEUES)
  ) u_ctrl_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_we),
    .waddr_i (queue_q),
    .wdata_i (ctrl_wdata),
    .raddr_i (match.queue),
    .rdata_o (ctrl_rdata)
  );

  tkmq_ram #(
    .Width ($bits(entry_t)),
    .Depth (StoreD)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  assign ctrl_cur  = ctrl_vld_q[queue_q] ? ctrl_rdata : CTRL_RESET;
  assign ent_base  = StoreAw'(queue_q * QUEUE_DEPTH);
  assign ent_waddr = ent_base + StoreAw'(ctrl_cur.wslot);
  assign ent_raddr = ent_base + StoreAw'(ctrl_cur.rslot);
  assign ent_wdata = '{seq: ctrl_cur.next_seq, data: payload_q};

  always_comb begin
    state_d    = state_q;
    done_d     = 1'b0;
    res_d      = '0;
    ctrl_we    = 1'b0;
    ctrl_wdata = ctrl_cur;
    ent_we     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CTRL;
        end
      end
      S_CTRL: begin
        done_d  = 1'b1;
        state_d = S_IDLE;
        if (!hit_q) begin
          res_d.status = ST_NO_TOPIC;
        end else if (op_q == OP_PUSH) begin
          if (ctrl_cur.fill == FillW'(QUEUE_DEPTH)) begin
            res_d.status = ST_FULL;
          end else begin
            ent_we              = 1'b1;
            ctrl_we             = 1'b1;
            ctrl_wdata.wslot    = slot_advance(ctrl_cur.wslot);
            ctrl_wdata.fill     = ctrl_cur.fill + FillW'(1);
            ctrl_wdata.next_seq = ctrl_cur.next_seq + 16'd1;
            res_d.status        = ST_OK;
            res_d.entry_number  = ctrl_cur.next_seq;
          end
        end else if (ctrl_cur.fill == '0) begin
          res_d.status = ST_EMPTY;
        end else begin
          done_d  = 1'b0;
          state_d = S_POP;
        end
      end
      S_POP: begin
        ctrl_we              = 1'b1;
        ctrl_wdata           = ctrl_hold_q;
        ctrl_wdata.rslot     = slot_advance(ctrl_hold_q.rslot);
        ctrl_wdata.fill      = ctrl_hold_q.fill - FillW'(1);
        ctrl_wdata.last_read = signed'({1'b0, ent_rdata.seq});
        done_d               = 1'b1;
        res_d.status         = ST_OK;
        res_d.entry_number   = ent_rdata.seq;
        res_d.data_out       = ent_rdata.data;
        state_d              = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      done_q     <= 1'b0;
      ctrl_vld_q <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      if (ctrl_we) begin
        ctrl_vld_q[queue_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      op_q      <= cmd_i.operation;
      payload_q <= cmd_i.payload;
      hit_q     <= match.hit;
      queue_q   <= match.queue;
    end
    if (state_q == S_CTRL) begin
      ctrl_hold_q <= ctrl_cur;
    end
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == S_CTRL || $past(state_q) == S_POP))
    else $error("result strobe without a finished command");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted command did not raise busy");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OK) |->
      (result_o.entry_number == 16'd0 && result_o.data_out == 32'd0))
    else $error("failed command returned nonzero fields");

  a_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_we |-> (state_q == S_CTRL && hit_q && op_q == OP_PUSH))
    else $error("entry write outside a push");

endmodule

### design/tkmq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tkmq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/tkmq_lookup.sv
// Topic registers per queue and the priority match of a topic to a queue.
module tkmq_lookup (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tkmq_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [tkmq_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic [7:0]                       topic_i,
  output tkmq_pkg::lookup_t                match_o
);
  import tkmq_pkg::*;

  logic [CfgDataW-1:0] topic_q [NUM_QUEUES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        topic_q[i] <= '1;
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        if (i < NUM_CFG_REGS && cfg_idx_i == CfgIdxW'(i)) begin
          topic_q[i] <= cfg_wdata_i;
        end
      end
    end
  end

  always_comb begin
    match_o = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!topic_q[i][CfgDataW-1] && topic_q[i][7:0] == topic_i) begin
        match_o.hit   = 1'b1;
        match_o.queue = QueueW'(i);
      end
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for the topic-keyed multi-queue FIFO unit.
`timescale 1ns / 100ps

module testbench;
  import tkmq_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [CfgIdxW-1:0] REG_TOPIC_Q0 = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] REG_TOPIC_Q1 = CfgIdxW'(1);
  localparam logic [CfgDataW-1:0] TOPIC_UNUSED = 9'h1FF;
  localparam logic [CfgDataW-1:0] TOPIC_MOST_NEG = 9'h100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                start_i = 1'b0;
  cmd_t                cmd_i = '0;
  logic                busy_o;
  logic                done_o;
  res_t                result_o;

  logic signed [CfgDataW-1:0] topic_reg   [NUM_QUEUES];
  logic [SlotW-1:0]           wr_ptr      [NUM_QUEUES];
  logic [SlotW-1:0]           rd_ptr      [NUM_QUEUES];
  logic [FillW-1:0]           depth_used  [NUM_QUEUES];
  logic [15:0]                seq_counter [NUM_QUEUES];
  entry_t                     entry_mem   [StoreD];

  res_t pending_results[$];
  int   errors = 0;
  int   cycles = 0;
  int   n_ok = 0, n_no_topic = 0, n_full = 0, n_empty = 0;

  topic_keyed_multi_queue_fifo_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .start_i    (start_i),
    .cmd_i      (cmd_i),
    .busy_o     (busy_o),
    .done_o     (done_o),
    .result_o   (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic res_t fifo_outcome(input cmd_t c);
    res_t r;
    logic hit;
    int   q;
    int   at;
    r = '0;
    r.status = ST_NO_TOPIC;
    hit = 1'b0;
    q = 0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (!hit && !topic_reg[i][CfgDataW-1] && topic_reg[i][7:0] == c.topic) begin
        hit = 1'b1;
        q = i;
      end
    end
    if (hit) begin
      if (c.operation == OP_PUSH) begin
        if (depth_used[q] == FillW'(QUEUE_DEPTH)) begin
          r.status = ST_FULL;
        end else begin
          at = q * QUEUE_DEPTH + int'(wr_ptr[q]);
          entry_mem[at].seq = seq_counter[q];
          entry_mem[at].data = c.payload;
          r.status = ST_OK;
          r.entry_number = seq_counter[q];
          wr_ptr[q] = (wr_ptr[q] == SlotW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr[q] + 1'b1;
          depth_used[q] = depth_used[q] + 1'b1;
          seq_counter[q] = seq_counter[q] + 16'd1;
        end
      end else begin
        if (depth_used[q] == '0) begin
          r.status = ST_EMPTY;
        end else begin
          at = q * QUEUE_DEPTH + int'(rd_ptr[q]);
          r.status = ST_OK;
          r.entry_number = entry_mem[at].seq;
          r.data_out = entry_mem[at].data;
          rd_ptr[q] = (rd_ptr[q] == SlotW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr[q] + 1'b1;
          depth_used[q] = depth_used[q] - 1'b1;
        end
      end
    end
    return r;
  endfunction

  // sample results mid-cycle, away from the driving edge
  always @(negedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      case (result_o.status)
        ST_OK:       n_ok++;
        ST_NO_TOPIC: n_no_topic++;
        ST_FULL:     n_full++;
        default:     n_empty++;
      endcase
      if (pending_results.size() == 0) begin
        $display("%0t unexpected word: status %0d number %0d data %h", $time,
                 result_o.status, result_o.entry_number, result_o.data_out);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result_o.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time,
                   want.status, result_o.status);
          errors++;
        end
        if (result_o.entry_number !== want.entry_number) begin
          $display("%0t entry_number mismatch: expected %0d actual %0d", $time,
                   want.entry_number, result_o.entry_number);
          errors++;
        end
        if (result_o.data_out !== want.data_out) begin
          $display("%0t data_out mismatch: expected %h actual %h", $time,
                   want.data_out, result_o.data_out);
          errors++;
        end
      end
    end
  end

  task automatic apply_reset();
    for (int i = 0; i < NUM_QUEUES; i++) begin
      topic_reg[i] = -9'sd1;
      wr_ptr[i] = '0;
      rd_ptr[i] = '0;
      depth_used[i] = '0;
      seq_counter[i] = '0;
    end
    for (int i = 0; i < StoreD; i++) entry_mem[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  endtask

  task automatic issue_cmd(input logic op, input logic [7:0] topic, input logic [31:0] payload);
    cmd_t c;
    c.operation = op;
    c.topic = topic;
    c.payload = payload;
    start_i <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy_o);
    pending_results.push_back(fifo_outcome(c));
  endtask

  task automatic idle(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_topic(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (int'(idx) < NUM_QUEUES) topic_reg[idx] = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] pick_topic(input logic [CfgDataW-1:0] other);
    case ($urandom_range(0, 6))
      0:       return TOPIC_UNUSED;
      1:       return TOPIC_MOST_NEG;
      2:       return 9'h000;
      3:       return 9'h0FF;
      4:       return other;
      default: return CfgDataW'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic test_unused_queues();
    issue_cmd(OP_PUSH, 8'd0, 32'h1234_5678);
    issue_cmd(OP_POP, 8'd255, 32'h0);
    issue_cmd(OP_PUSH, 8'd128, 32'hFFFF_FFFF);
    drain_results();
  endtask

  task automatic test_fill_and_drain();
    set_topic(REG_TOPIC_Q0, 9'h000);
    set_topic(REG_TOPIC_Q1, 9'h0FF);
    issue_cmd(OP_PUSH, 8'd0, 32'h0000_0000);
    issue_cmd(OP_PUSH, 8'd0, 32'hFFFF_FFFF);
    issue_cmd(OP_PUSH, 8'd0, 32'hA5A5_A5A5);
    issue_cmd(OP_PUSH, 8'd0, 32'h5A5A_5A5A);
    issue_cmd(OP_PUSH, 8'd0, 32'hDEAD_BEEF);
    repeat (5) issue_cmd(OP_POP, 8'd0, 32'hFFFF_FFFF);
    issue_cmd(OP_PUSH, 8'd255, 32'hFFFF_FFFF);
    issue_cmd(OP_POP, 8'd255, 32'h0);
    drain_results();
  endtask

  task automatic test_duplicate_and_negative();
    set_topic(REG_TOPIC_Q0, 9'd7);
    set_topic(REG_TOPIC_Q1, 9'd7);
    issue_cmd(OP_PUSH, 8'd7, 32'hC0FF_EE00);
    issue_cmd(OP_POP, 8'd7, 32'h0);
    drain_results();
    set_topic(REG_TOPIC_Q0, TOPIC_MOST_NEG);
    issue_cmd(OP_PUSH, 8'd0, 32'h0BAD_F00D);
    drain_results();
  endtask

  task automatic test_ring_wrap();
    set_topic(REG_TOPIC_Q0, 9'd42);
    set_topic(REG_TOPIC_Q1, TOPIC_UNUSED);
    for (int r = 0; r < 25; r++) begin
      repeat (QUEUE_DEPTH) issue_cmd(OP_PUSH, 8'd42, $urandom);
      repeat (QUEUE_DEPTH) issue_cmd(OP_POP, 8'd42, $urandom);
    end
    drain_results();
  endtask

  task automatic test_random_mix();
    int burst_left;
    int push_pct;
    bit gaps_on;
    logic [7:0] topic;
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 0) begin
        set_topic(REG_TOPIC_Q0, 9'h0FF);
        set_topic(REG_TOPIC_Q1, 9'h000);
      end else begin
        set_topic(REG_TOPIC_Q0, pick_topic(topic_reg[1]));
        set_topic(REG_TOPIC_Q1, pick_topic(topic_reg[0]));
      end
      push_pct = $urandom_range(25, 75);
      gaps_on = (ph % 3) != 2;
      burst_left = 0;
      for (int i = 0; i < 175; i++) begin
        if (burst_left == 0) begin
          if (gaps_on) idle($urandom_range(0, 6));
          burst_left = $urandom_range(1, 24);
        end
        if ($urandom_range(0, 99) < 75) topic = topic_reg[$urandom_range(0, 1)][7:0];
        else topic = 8'($urandom_range(0, 255));
        issue_cmd(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, topic, $urandom);
        burst_left--;
      end
      drain_results();
    end
  endtask

  initial begin
    apply_reset();
    test_unused_queues();
    test_fill_and_drain();
    test_duplicate_and_negative();
    test_ring_wrap();
    test_random_mix();
    drain_results();
    repeat (8) @(posedge clk_i);
    $display("Checked %0d words: %0d ok, %0d topic miss, %0d full, %0d empty.",
             n_ok + n_no_topic + n_full + n_empty, n_ok, n_no_topic, n_full, n_empty);
    $display("Covered unused, duplicate and negative topics, slot wraparound and random mixes.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
